// ===== sv/apsp_pkg.sv =====
package apsp_pkg;

  localparam int COORD_IN_W = 12;
  localparam int IDX_IN_W   = 6;
  localparam int DIST_W     = 20;
  localparam int VIA_W      = 6;
  localparam int TOT_W      = 7;
  localparam int LIM_W      = 13;

  localparam logic [DIST_W-1:0] DIST_INF    = '1;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(25);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } apsp_op_t;

  typedef enum logic [1:0] {
    RES_SOLVED  = 2'd0,
    RES_READ_OK = 2'd1,
    RES_ERROR   = 2'd2
  } apsp_res_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_SOLVE,
    EM_READ,
    EM_ERR
  } apsp_emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_BLD_RD,
    ST_BLD_MUL,
    ST_BLD_SUM,
    ST_BLD_SQRT,
    ST_BLD_WR,
    ST_FW_IK,
    ST_FW_CHK,
    ST_FW_RD,
    ST_FW_WR,
    ST_DONE
  } apsp_state_t;

  typedef struct packed {
    logic       ld_point;
    logic       clr_cnt;
    logic       rd_req;
    logic       sq_mul;
    logic       sq_init;
    logic       sq_step;
    logic       bld_wr;
    logic       fw_ik;
    logic       fw_chk;
    logic       fw_rd;
    logic       fw_wr;
    apsp_emit_t emit;
  } apsp_cmd_t;

  typedef struct packed {
    logic full;
    logic rd_ok;
    logic dik_inf;
    logic sq_done;
    logic out_free;
  } apsp_sts_t;

endpackage

// ===== sv/apsp_if.sv =====
interface apsp_in_if import apsp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [COORD_IN_W-1:0] vertex_x;
  logic [COORD_IN_W-1:0] vertex_y;
  logic [IDX_IN_W-1:0]   row;
  logic [IDX_IN_W-1:0]   col;
  modport source(output valid, command, vertex_x, vertex_y, row, col, input ready);
  modport sink(input valid, command, vertex_x, vertex_y, row, col, output ready);
endinterface

interface apsp_out_if import apsp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] path_length;
  logic [VIA_W-1:0]  via_vertex;
  logic [TOT_W-1:0]  vertex_total;
  logic [1:0]        status;
  modport source(output valid, path_length, via_vertex, vertex_total, status, input ready);
  modport sink(input valid, path_length, via_vertex, vertex_total, status, output ready);
endinterface

interface apsp_cfg_if import apsp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] link_limit;
  modport source(output valid, link_limit, input ready);
  modport sink(input valid, link_limit, output ready);
endinterface

// ===== sv/apsp_ctrl.sv =====
module apsp_ctrl import apsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_command,
  output logic             in_ready,
  input  apsp_sts_t        sts,
  input  logic [CNT_W-1:0] cnt,
  output apsp_cmd_t        cmd,
  output logic [IDX_W-1:0] i_idx,
  output logic [IDX_W-1:0] j_idx,
  output logic [IDX_W-1:0] k_idx
);

  apsp_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             accept, i_last, j_last, k_last, adv_i;

  assign accept = in_valid && in_ready;
  assign i_last = (CNT_W'(i_r) + CNT_W'(1)) == cnt;
  assign j_last = (CNT_W'(j_r) + CNT_W'(1)) == cnt;
  assign k_last = (CNT_W'(k_r) + CNT_W'(1)) == cnt;
  assign i_idx  = i_r;
  assign j_idx  = j_r;
  assign k_idx  = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    adv_i     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_SOLVE) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = (cnt == '0) ? ST_DONE : ST_BLD_RD;
        end else if (accept && in_command == CMD_READ && sts.rd_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:    state_nxt = ST_IDLE;
      ST_BLD_RD:  state_nxt = ST_BLD_MUL;
      ST_BLD_MUL: state_nxt = ST_BLD_SUM;
      ST_BLD_SUM: state_nxt = ST_BLD_SQRT;
      ST_BLD_SQRT: begin
        if (sts.sq_done) state_nxt = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = ST_FW_IK;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = ST_BLD_RD;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_BLD_RD;
        end
      end
      ST_FW_IK: state_nxt = ST_FW_CHK;
      ST_FW_CHK: begin
        // row i has no path to k: nothing in it can improve
        if (sts.dik_inf) begin
          adv_i = 1'b1;
        end else begin
          j_nxt     = '0;
          state_nxt = ST_FW_RD;
        end
      end
      ST_FW_RD: state_nxt = ST_FW_WR;
      ST_FW_WR: begin
        if (j_last) begin
          adv_i = 1'b1;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_FW_RD;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (adv_i) begin
      if (i_last) begin
        i_nxt = '0;
        if (k_last) begin
          state_nxt = ST_DONE;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = ST_FW_IK;
        end
      end else begin
        i_nxt     = i_r + IDX_W'(1);
        state_nxt = ST_FW_IK;
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.emit = EM_NONE;
    in_ready = (state_r == ST_IDLE) && sts.out_free;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_LOAD: begin
              if (sts.full) cmd.emit = EM_ERR;
              else cmd.ld_point = 1'b1;
            end
            CMD_READ: begin
              if (sts.rd_ok) cmd.rd_req = 1'b1;
              else cmd.emit = EM_ERR;
            end
            CMD_CLEAR: cmd.clr_cnt = 1'b1;
            default: ;
          endcase
        end
      end
      ST_READ:     cmd.emit    = EM_READ;
      ST_BLD_MUL:  cmd.sq_mul  = 1'b1;
      ST_BLD_SUM:  cmd.sq_init = 1'b1;
      ST_BLD_SQRT: cmd.sq_step = 1'b1;
      ST_BLD_WR:   cmd.bld_wr  = 1'b1;
      ST_FW_IK:    cmd.fw_ik   = 1'b1;
      ST_FW_CHK:   cmd.fw_chk  = 1'b1;
      ST_FW_RD:    cmd.fw_rd   = 1'b1;
      ST_FW_WR:    cmd.fw_wr   = 1'b1;
      ST_DONE:     cmd.emit    = EM_SOLVE;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_wr_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLD_WR |-> $past(state_r) == ST_BLD_SQRT)
    else $error("table entry written without finished root");

  a_solve_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_SOLVE && cnt != '0) |=> state_r == ST_BLD_RD)
    else $error("solve did not start table build");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FW_WR || state_r == ST_BLD_WR) |-> CNT_W'(j_r) < cnt)
    else $error("column index beyond loaded vertices");
`endif

endmodule

// ===== sv/apsp_dp.sv =====
module apsp_dp import apsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 12,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  apsp_cmd_t             cmd,
  output apsp_sts_t             sts,
  output logic [CNT_W-1:0]      cnt,
  input  logic [IDX_W-1:0]      i_idx,
  input  logic [IDX_W-1:0]      j_idx,
  input  logic [IDX_W-1:0]      k_idx,
  input  logic [COORD_IN_W-1:0] in_x,
  input  logic [COORD_IN_W-1:0] in_y,
  input  logic [IDX_IN_W-1:0]   in_row,
  input  logic [IDX_IN_W-1:0]   in_col,
  input  logic                  cfg_valid,
  input  logic [LIM_W-1:0]      cfg_limit,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [DIST_W-1:0]     out_path_length,
  output logic [VIA_W-1:0]      out_via_vertex,
  output logic [TOT_W-1:0]      out_vertex_total,
  output logic [1:0]            out_status
);

  localparam int CW    = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
  localparam int RT_W  = CW + 1;
  localparam int SQ_W  = 2 * CW + 2;
  localparam int SQC_W = $clog2(RT_W);
  localparam int DEPTH = 1 << (2 * IDX_W);

  logic [CW-1:0]     pt_x_mem [MAX_VERTICES];
  logic [CW-1:0]     pt_y_mem [MAX_VERTICES];
  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [IDX_W-1:0]  via_mem  [DEPTH];

  logic [CNT_W-1:0]    cnt_r;
  logic [LIM_W-1:0]    limit_r;
  logic [CW-1:0]       xi_rd, xj_rd, yi_rd, yj_rd;
  logic signed [CW:0]  dx, dy;
  logic signed [SQ_W-1:0] dx_sq, dy_sq;
  logic [SQ_W-1:0]     sqx_r, sqy_r, val_r;
  logic [RT_W:0]       rem_r, rem_nxt;
  logic [RT_W-1:0]     root_r, root_nxt;
  logic [SQC_W-1:0]    sq_cnt_r;
  logic [RT_W+2:0]     rem_sh, trial;
  logic                trial_ok;

  logic [2*IDX_W-1:0]  addr_a, addr_b, waddr;
  logic [DIST_W-1:0]   rd_a, rd_b, dik_r, sat, dist_bld, wdist;
  logic [IDX_W-1:0]    via_rd, wvia;
  logic [DIST_W:0]     sum;
  logic                upd, wr_en;

  logic                out_valid_r;
  logic [DIST_W-1:0]   plen_r;
  logic [VIA_W-1:0]    via_r;
  logic [TOT_W-1:0]    tot_r;
  logic [1:0]          status_r;

  assign cnt = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      if (cmd.clr_cnt) cnt_r <= '0;
      else if (cmd.ld_point) cnt_r <= cnt_r + CNT_W'(1);
      if (cfg_valid) limit_r <= cfg_limit;
    end
  end

  // point list: one write port, two registered read ports (vertex i and j)
  always_ff @(posedge clk) begin
    if (cmd.ld_point) begin
      pt_x_mem[IDX_W'(cnt_r)] <= in_x[CW-1:0];
      pt_y_mem[IDX_W'(cnt_r)] <= in_y[CW-1:0];
    end
    xi_rd <= pt_x_mem[i_idx];
    yi_rd <= pt_y_mem[i_idx];
    xj_rd <= pt_x_mem[j_idx];
    yj_rd <= pt_y_mem[j_idx];
  end

  assign dx    = $signed({1'b0, xi_rd}) - $signed({1'b0, xj_rd});
  assign dy    = $signed({1'b0, yi_rd}) - $signed({1'b0, yj_rd});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  // restoring square root, one result bit per step
  assign rem_sh   = {rem_r, val_r[SQ_W-1 -: 2]};
  assign trial    = (RT_W+3)'({root_r, 2'b01});
  assign trial_ok = rem_sh >= trial;
  assign rem_nxt  = trial_ok ? (RT_W+1)'(rem_sh - trial) : (RT_W+1)'(rem_sh);
  assign root_nxt = {root_r[RT_W-2:0], trial_ok};

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      sqx_r <= $unsigned(dx_sq);
      sqy_r <= $unsigned(dy_sq);
    end
    if (cmd.sq_init) begin
      val_r    <= sqx_r + sqy_r;
      rem_r    <= '0;
      root_r   <= '0;
      sq_cnt_r <= '0;
    end else if (cmd.sq_step) begin
      val_r    <= val_r << 2;
      rem_r    <= rem_nxt;
      root_r   <= root_nxt;
      sq_cnt_r <= sq_cnt_r + SQC_W'(1);
    end
    if (cmd.fw_chk) dik_r <= rd_a;
  end

  assign dist_bld = ((LIM_W+1)'(root_r) <= (LIM_W+1)'(limit_r)) ? DIST_W'(root_r) : DIST_INF;

  always_comb begin
    addr_a = {i_idx, j_idx};
    if (cmd.rd_req) addr_a = {IDX_W'(in_row), IDX_W'(in_col)};
    else if (cmd.fw_ik) addr_a = {i_idx, k_idx};
    else if (cmd.fw_rd) addr_a = {k_idx, j_idx};
  end
  assign addr_b = {i_idx, j_idx};
  assign waddr  = {i_idx, j_idx};

  // relaxation: port a holds dist(k,j), port b dist(i,j)
  assign sum   = {1'b0, dik_r} + {1'b0, rd_a};
  assign sat   = (sum >= {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_W-1:0];
  assign upd   = cmd.fw_wr && (rd_a != DIST_INF) && (rd_b > sat);
  assign wr_en = cmd.bld_wr || upd;
  assign wdist = cmd.bld_wr ? dist_bld : sat;
  assign wvia  = cmd.bld_wr ? i_idx : k_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[waddr] <= wdist;
      via_mem[waddr]  <= wvia;
    end
    rd_a   <= dist_mem[addr_a];
    rd_b   <= dist_mem[addr_b];
    via_rd <= via_mem[addr_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      plen_r <= (cmd.emit == EM_READ) ? rd_a : '0;
      via_r  <= (cmd.emit == EM_READ) ? VIA_W'(via_rd) : '0;
      tot_r  <= TOT_W'(cnt_r);
      case (cmd.emit)
        EM_SOLVE: status_r <= RES_SOLVED;
        EM_READ:  status_r <= RES_READ_OK;
        default:  status_r <= RES_ERROR;
      endcase
    end
  end

  assign sts.full     = cnt_r == CNT_W'(MAX_VERTICES);
  assign sts.rd_ok    = (32'(in_row) < 32'(cnt_r)) && (32'(in_col) < 32'(cnt_r));
  assign sts.dik_inf  = rd_a == DIST_INF;
  assign sts.sq_done  = sq_cnt_r == SQC_W'(RT_W - 1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_path_length  = plen_r;
  assign out_via_vertex   = via_r;
  assign out_vertex_total = tot_r;
  assign out_status       = status_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit != EM_NONE |-> (!out_valid_r || out_ready))
    else $error("result beat overwrites one not yet taken");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_VERTICES)
    else $error("vertex count beyond capacity");
`endif

endmodule

// ===== sv/all_pairs_shortest_path_core.sv =====
// All-pairs shortest path over up to MAX_VERTICES loaded points. A read does a
// registered table read, then sends the result beat. A solve first builds the
// table entry by entry (two squaring multipliers, then a restoring square root
// giving one bit per cycle, CW = min(COORD_BITS,12)), then runs Floyd-Warshall
// through one distance memory with two read ports and one write port, rows with
// no path to k skipped. No input is taken during a solve. Unreachable pairs
// report path_length all ones. The table contents after a clear stay until the
// next solve; no clearing pass runs after reset.
module all_pairs_shortest_path_core import apsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 12
) (
  input logic         clk,
  input logic         rst_n,
  apsp_in_if.sink     in_ch,
  apsp_out_if.source  out_ch,
  apsp_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  apsp_cmd_t        cmd;
  apsp_sts_t        sts;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] i_idx, j_idx, k_idx;

  assign cfg_ch.ready = 1'b1;

  apsp_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cnt        (cnt),
    .cmd        (cmd),
    .i_idx      (i_idx),
    .j_idx      (j_idx),
    .k_idx      (k_idx)
  );

  apsp_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cnt              (cnt),
    .i_idx            (i_idx),
    .j_idx            (j_idx),
    .k_idx            (k_idx),
    .in_x             (in_ch.vertex_x),
    .in_y             (in_ch.vertex_y),
    .in_row           (in_ch.row),
    .in_col           (in_ch.col),
    .cfg_valid        (cfg_ch.valid),
    .cfg_limit        (cfg_ch.link_limit),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_path_length  (out_ch.path_length),
    .out_via_vertex   (out_ch.via_vertex),
    .out_vertex_total (out_ch.vertex_total),
    .out_status       (out_ch.status)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench import apsp_pkg::*;;

  localparam int NV        = 64;
  localparam int CYC_LIMIT = 4000000;

  typedef struct packed {
    logic [DIST_W-1:0] path_length;
    logic [VIA_W-1:0]  via_vertex;
    logic [TOT_W-1:0]  vertex_total;
    apsp_res_t         status;
  } path_beat_t;

  typedef struct {
    apsp_op_t   op;
    int         x, y, r, c;
    bit         fixed;
    path_beat_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  apsp_in_if  in_ch();
  apsp_out_if out_ch();
  apsp_cfg_if cfg_ch();

  all_pairs_shortest_path_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [LIM_W-1:0]       limit_q;
  logic [COORD_IN_W-1:0]  px [NV];
  logic [COORD_IN_W-1:0]  py [NV];
  logic [DIST_W-1:0]      dist_tab [NV*NV];
  logic [VIA_W-1:0]       via_tab [NV*NV];
  bit                     filled [NV*NV];
  int                     n_pts;

  path_beat_t pending_beats[$];
  int         mismatches;
  bit         calm;
  bit         hold_req;
  longint     cycles;
  stim_row_t  plan[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_LOAD;
    in_ch.vertex_x  <= '0;
    in_ch.vertex_y  <= '0;
    in_ch.row       <= '0;
    in_ch.col       <= '0;
    out_ch.ready    <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.link_limit <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned floor_root(longint unsigned v);
    longint unsigned r;
    r = longint'($sqrt(real'(v)));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return int'(r);
  endfunction

  function automatic void solve_paths();
    int d, s;
    longint dx, dy;
    for (int i = 0; i < n_pts; i++)
      for (int j = 0; j < n_pts; j++) begin
        via_tab[i*NV+j] = VIA_W'(i);
        filled[i*NV+j]  = 1'b1;
        if (i == j) dist_tab[i*NV+j] = '0;
        else begin
          dx = longint'(px[i]) - longint'(px[j]);
          dy = longint'(py[i]) - longint'(py[j]);
          d  = floor_root(dx * dx + dy * dy);
          dist_tab[i*NV+j] = (d <= limit_q && d < DIST_INF) ? DIST_W'(d) : DIST_INF;
        end
      end
    for (int k = 0; k < n_pts; k++)
      for (int i = 0; i < n_pts; i++) begin
        if (dist_tab[i*NV+k] == DIST_INF) continue;
        for (int j = 0; j < n_pts; j++) begin
          if (dist_tab[k*NV+j] == DIST_INF) continue;
          s = dist_tab[i*NV+k] + dist_tab[k*NV+j];
          if (s >= DIST_INF) s = DIST_INF;
          if (dist_tab[i*NV+j] > s) begin
            dist_tab[i*NV+j] = DIST_W'(s);
            via_tab[i*NV+j]  = VIA_W'(k);
          end
        end
      end
  endfunction

  // returns 1 when the command produces a beat
  function automatic bit predict_beat(stim_row_t t, output path_beat_t b);
    b = '0;
    case (t.op)
      CMD_LOAD: begin
        if (n_pts < NV) begin
          px[n_pts] = COORD_IN_W'(t.x);
          py[n_pts] = COORD_IN_W'(t.y);
          n_pts++;
          return 1'b0;
        end
        b.status = RES_ERROR;
      end
      CMD_SOLVE: begin
        solve_paths();
        b.status = RES_SOLVED;
      end
      CMD_READ: begin
        if (t.r < n_pts && t.c < n_pts) begin
          b.path_length = dist_tab[t.r*NV+t.c];
          b.via_vertex  = via_tab[t.r*NV+t.c];
          b.status      = RES_READ_OK;
        end else b.status = RES_ERROR;
      end
      default: begin
        n_pts = 0;
        return 1'b0;
      end
    endcase
    b.vertex_total = TOT_W'(n_pts);
    return 1'b1;
  endfunction

  task automatic send_cmd(stim_row_t t);
    path_beat_t b;
    if (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= t.op;
    in_ch.vertex_x <= COORD_IN_W'(t.x);
    in_ch.vertex_y <= COORD_IN_W'(t.y);
    in_ch.row      <= IDX_IN_W'(t.r);
    in_ch.col      <= IDX_IN_W'(t.c);
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (predict_beat(t, b)) pending_beats.insert(pending_beats.size(), t.fixed ? t.want : b);
  endtask

  task automatic send(apsp_op_t op, int x = 0, int y = 0, int r = 0, int c = 0);
    stim_row_t t;
    t = '{op: op, x: x, y: y, r: r, c: c, fixed: 1'b0, want: '0};
    send_cmd(t);
  endtask

  task automatic plan_row(apsp_op_t op, int x, int y, int r, int c, bit fixed = 1'b0,
                          int len = 0, int via = 0, int tot = 0,
                          apsp_res_t st = RES_ERROR);
    stim_row_t t;
    t = '{op: op, x: x, y: y, r: r, c: c, fixed: fixed,
          want: '{DIST_W'(len), VIA_W'(via), TOT_W'(tot), st}};
    plan.insert(plan.size(), t);
  endtask

  // drop valid, wait for all beats, then let any trailing load or clear settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(int lim);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.link_limit <= LIM_W'(lim);
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    limit_q = LIM_W'(lim);
  endtask

  task automatic read_some(int cnt, bit wide);
    int r, c;
    for (int i = 0; i < cnt; i++) begin
      if (wide || n_pts == 0 || $urandom_range(9) == 0) begin
        r = $urandom_range(63);
        c = $urandom_range(63);
      end else begin
        r = $urandom_range(n_pts - 1);
        c = $urandom_range(n_pts - 1);
      end
      // never touch a table entry no solve has written
      if (r < n_pts && c < n_pts && !filled[r*NV+c]) r = 63;
      send(CMD_READ, 0, 0, r, c);
    end
  endtask

  // receive side
  initial begin
    int hold_left;
    path_beat_t got, want;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.path_length, out_ch.via_vertex, out_ch.vertex_total,
                apsp_res_t'(out_ch.status)};
        if (pending_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", got);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected len=%0d via=%0d tot=%0d st=%0d, got len=%0d via=%0d tot=%0d st=%0d",
                       want.path_length, want.via_vertex, want.vertex_total, want.status,
                       got.path_length, got.via_vertex, got.vertex_total, got.status);
          end
        end
      end
      if (hold_req && hold_left == 0) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    int n, span, bx, by, lims[6];
    cycles = 0;
    mismatches = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    limit_q = LIMIT_RESET;
    n_pts = 0;
    foreach (filled[i]) filled[i] = 1'b0;

    // directed: fresh block, two far corners, a 3-4-5 pair, a two-hop chain
    plan_row(CMD_READ, 0, 0, 0, 0, 1, 0, 0, 0, RES_ERROR);
    plan_row(CMD_SOLVE, 0, 0, 0, 0, 1, 0, 0, 0, RES_SOLVED);
    plan_row(CMD_LOAD, 0, 0, 0, 0);
    plan_row(CMD_LOAD, 4095, 4095, 0, 0);
    plan_row(CMD_LOAD, 3, 4, 0, 0);
    plan_row(CMD_LOAD, 4095, 0, 0, 0);
    plan_row(CMD_SOLVE, 0, 0, 0, 0, 1, 0, 0, 4, RES_SOLVED);
    plan_row(CMD_READ, 0, 0, 0, 2, 1, 5, 0, 4, RES_READ_OK);
    plan_row(CMD_READ, 0, 0, 0, 1, 1, DIST_INF, 0, 4, RES_READ_OK);
    plan_row(CMD_READ, 0, 0, 2, 2, 1, 0, 2, 4, RES_READ_OK);
    plan_row(CMD_READ, 0, 0, 3, 0, 1, DIST_INF, 3, 4, RES_READ_OK);
    plan_row(CMD_READ, 0, 0, 1, 3);
    plan_row(CMD_READ, 0, 0, 4, 0, 1, 0, 0, 4, RES_ERROR);
    plan_row(CMD_READ, 0, 0, 0, 63, 1, 0, 0, 4, RES_ERROR);
    plan_row(CMD_READ, 0, 0, 63, 63, 1, 0, 0, 4, RES_ERROR);
    plan_row(CMD_CLEAR, 0, 0, 0, 0);
    plan_row(CMD_READ, 0, 0, 0, 0, 1, 0, 0, 0, RES_ERROR);
    plan_row(CMD_LOAD, 10, 0, 0, 0);
    plan_row(CMD_LOAD, 30, 0, 0, 0);
    plan_row(CMD_LOAD, 50, 0, 0, 0);
    plan_row(CMD_SOLVE, 0, 0, 0, 0, 1, 0, 0, 3, RES_SOLVED);
    plan_row(CMD_READ, 0, 0, 0, 2, 1, 40, 1, 3, RES_READ_OK);
    plan_row(CMD_READ, 0, 0, 2, 0, 1, 40, 1, 3, RES_READ_OK);
    plan_row(CMD_READ, 0, 0, 1, 2, 1, 20, 1, 3, RES_READ_OK);

    @(posedge rst_n);
    @(posedge clk);
    foreach (plan[i]) send_cmd(plan[i]);

    // full list: loads past the end are refused
    send(CMD_CLEAR);
    for (int i = 0; i < NV + 2; i++)
      send(CMD_LOAD, $urandom_range(4095), $urandom_range(4095));
    send(CMD_READ, 0, 0, 0, 0);
    send(CMD_CLEAR);

    lims = '{0, 5792, 25, 1, 300, 8191};
    for (int ph = 0; ph < 30; ph++) begin
      calm = (ph >= 10 && ph < 16);
      if (ph % 5 == 0) set_limit(lims[(ph / 5) % 6]);
      else if (ph % 5 == 3) set_limit($urandom_range(5792));
      send(CMD_CLEAR);
      n = (ph % 9 == 4) ? $urandom_range(14, 20) : $urandom_range(1, 9);
      span = (ph % 4 == 0) ? 4095 : ((limit_q > 2000) ? 2000 : limit_q * 2 + 3);
      bx = $urandom_range(4095 - span);
      by = $urandom_range(4095 - span);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) == 0 && n_pts > 0)
          send(CMD_LOAD, px[n_pts-1], py[n_pts-1]);   // duplicate point
        else
          send(CMD_LOAD, bx + $urandom_range(span), by + $urandom_range(span));
      end
      read_some($urandom_range(0, 2), 1);
      send(CMD_SOLVE);
      if (ph == 12) begin
        hold_req = 1'b1;
        read_some(40, 0);
      end else read_some($urandom_range(20, 40), 0);
      if (ph % 6 == 5) begin
        // points loaded after the solve read the old table
        send(CMD_LOAD, $urandom_range(4095), $urandom_range(4095));
        read_some(5, 0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
